// File: rtl/jsu_pkg.sv
// Shared types and constants for the JSON string unescape unit.
package jsu_pkg;

	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	localparam logic [15:0] SUR_HI_BASE = 16'hD800;
	localparam logic [15:0] SUR_LO_BASE = 16'hDC00;
	localparam logic [15:0] SUR_END     = 16'hE000;
	localparam logic [20:0] SUPP_BASE   = 21'h10000;

	typedef enum logic [2:0] {
		PH_NORMAL,
		PH_ESCAPE,
		PH_HEX,
		PH_CONT,
		PH_DONE
	} phase_t;

	typedef enum logic [1:0] {
		ST_RUN  = 2'd0,
		ST_OK   = 2'd1,
		ST_FAIL = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		ERR_NONE      = 3'd0,
		ERR_EARLY_END = 3'd1,
		ERR_ESCAPE    = 3'd2,
		ERR_HEX       = 3'd3,
		ERR_SURROGATE = 3'd4,
		ERR_UTF8      = 3'd5
	} err_t;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       at_end;
		logic       start_req;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       byte_valid;
		logic [1:0] status;
		logic [2:0] error_kind;
		logic       last;
	} result_t;

	// All results caused by one input item; bytes[0] goes out first.
	typedef struct packed {
		logic [3:0][7:0] bytes;
		logic [1:0]      last_idx;
		logic [1:0]      status;
		logic [2:0]      error_kind;
	} burst_t;

endpackage

// File: rtl/jsu_front.sv
// Front end: byte classification, escape and UTF-8 decoding, at most one burst per item.
module jsu_front import jsu_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  in_item_t item,
	input  logic     take,
	output burst_t   burst,
	output logic     burst_vld
);

	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_BSL   = 8'h5C;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_B     = 8'h62;
	localparam logic [7:0] CH_F     = 8'h66;
	localparam logic [7:0] CH_N     = 8'h6E;
	localparam logic [7:0] CH_R     = 8'h72;
	localparam logic [7:0] CH_T     = 8'h74;
	localparam logic [7:0] CH_U     = 8'h75;

	phase_t      phase_q, phase_d, e_phase;
	logic [1:0]  hex_count_q, hex_count_d, e_hex_count;
	logic [15:0] hex_accum_q, hex_accum_d, e_hex_accum;
	logic        sur_pend_q, sur_pend_d, e_sur_pend;
	logic [9:0]  hsur_q, hsur_d, e_hsur;
	logic [1:0]  cont_left_q, cont_left_d, e_cont_left;

	logic [7:0]  b;
	logic [3:0]  hex_d;
	logic        hex_ok;
	logic [15:0] acc_new;
	logic [20:0] cp;
	logic        fail_now;
	err_t        fail_kind;
	logic        close_ok;

	function automatic burst_t encode_cp(input logic [20:0] v);
		burst_t r;
		r = '0;
		r.status     = ST_RUN;
		r.error_kind = ERR_NONE;
		if (v < 21'h80) begin
			r.bytes[0] = {1'b0, v[6:0]};
			r.last_idx = 2'd0;
		end else if (v < 21'h800) begin
			r.bytes[0] = {3'b110, v[10:6]};
			r.bytes[1] = {2'b10, v[5:0]};
			r.last_idx = 2'd1;
		end else if (v < SUPP_BASE) begin
			r.bytes[0] = {4'b1110, v[15:12]};
			r.bytes[1] = {2'b10, v[11:6]};
			r.bytes[2] = {2'b10, v[5:0]};
			r.last_idx = 2'd2;
		end else begin
			r.bytes[0] = {5'b11110, v[20:18]};
			r.bytes[1] = {2'b10, v[17:12]};
			r.bytes[2] = {2'b10, v[11:6]};
			r.bytes[3] = {2'b10, v[5:0]};
			r.last_idx = 2'd3;
		end
		return r;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_NORMAL;
			hex_count_q <= '0;
			hex_accum_q <= '0;
			sur_pend_q  <= 1'b0;
			hsur_q      <= '0;
			cont_left_q <= '0;
		end else if (take) begin
			phase_q     <= phase_d;
			hex_count_q <= hex_count_d;
			hex_accum_q <= hex_accum_d;
			sur_pend_q  <= sur_pend_d;
			hsur_q      <= hsur_d;
			cont_left_q <= cont_left_d;
		end
	end

	always_comb begin
		b = item.in_byte;
		hex_ok = 1'b1;
		hex_d  = '0;
		case (b) inside
			[8'h30:8'h39]: hex_d = 4'(b - 8'h30);
			[8'h61:8'h66]: hex_d = 4'(b - 8'h57);
			[8'h41:8'h46]: hex_d = 4'(b - 8'h37);
			default:       hex_ok = 1'b0;
		endcase
	end

	always_comb begin
		// start_req clears the state before the byte is looked at
		if (item.start_req) begin
			e_phase = PH_NORMAL; e_hex_count = '0; e_hex_accum = '0;
			e_sur_pend = 1'b0;   e_hsur = '0;      e_cont_left = '0;
		end else begin
			e_phase = phase_q;       e_hex_count = hex_count_q; e_hex_accum = hex_accum_q;
			e_sur_pend = sur_pend_q; e_hsur = hsur_q;           e_cont_left = cont_left_q;
		end

		phase_d = e_phase; hex_count_d = e_hex_count; hex_accum_d = e_hex_accum;
		sur_pend_d = e_sur_pend; hsur_d = e_hsur; cont_left_d = e_cont_left;

		acc_new   = {e_hex_accum[11:0], hex_d};
		cp        = {5'd0, acc_new};
		fail_now  = 1'b0;
		fail_kind = ERR_NONE;
		close_ok  = 1'b0;
		burst_vld = 1'b0;
		burst     = '0;
		burst.status     = ST_RUN;
		burst.error_kind = ERR_NONE;
		burst.bytes[0]   = b;

		if (e_phase == PH_DONE) begin
			burst_vld = 1'b0;
		end else if (item.at_end) begin
			fail_now = 1'b1; fail_kind = ERR_EARLY_END;
		end else begin
			case (e_phase)
				PH_NORMAL: begin
					if (e_sur_pend && b != CH_BSL) begin
						fail_now = 1'b1; fail_kind = ERR_SURROGATE;
					end else if (b == CH_QUOTE) begin
						close_ok = 1'b1;
					end else if (b == CH_BSL) begin
						phase_d = PH_ESCAPE;
					end else if (b inside {[8'h80:8'hBF]}) begin
						fail_now = 1'b1; fail_kind = ERR_UTF8;
					end else begin
						if (b >= 8'hC0) begin
							cont_left_d = (b >= 8'hF0) ? 2'd3 : (b >= 8'hE0) ? 2'd2 : 2'd1;
							phase_d = PH_CONT;
						end
						burst_vld = 1'b1;
					end
				end
				PH_ESCAPE: begin
					if (e_sur_pend && b != CH_U) begin
						fail_now = 1'b1; fail_kind = ERR_SURROGATE;
					end else begin
						phase_d   = PH_NORMAL;
						burst_vld = 1'b1;
						case (b)
							CH_QUOTE, CH_BSL, CH_SLASH: burst.bytes[0] = b;
							CH_B: burst.bytes[0] = 8'h08;
							CH_F: burst.bytes[0] = 8'h0C;
							CH_N: burst.bytes[0] = 8'h0A;
							CH_R: burst.bytes[0] = 8'h0D;
							CH_T: burst.bytes[0] = 8'h09;
							CH_U: begin
								burst_vld   = 1'b0;
								phase_d     = PH_HEX;
								hex_count_d = '0;
								hex_accum_d = '0;
							end
							default: begin
								burst_vld = 1'b0;
								fail_now  = 1'b1;
								fail_kind = ERR_ESCAPE;
							end
						endcase
					end
				end
				PH_HEX: begin
					if (!hex_ok) begin
						fail_now = 1'b1; fail_kind = ERR_HEX;
					end else if (e_hex_count != 2'd3) begin
						hex_accum_d = acc_new;
						hex_count_d = e_hex_count + 2'd1;
					end else begin
						phase_d = PH_NORMAL; hex_count_d = '0; hex_accum_d = '0;
						if (e_sur_pend) begin
							if (acc_new >= SUR_END || acc_new < SUR_LO_BASE) begin
								fail_now = 1'b1; fail_kind = ERR_SURROGATE;
							end else begin
								// combine both halves into a supplementary code point
								cp = {1'b0, e_hsur, acc_new[9:0]} + SUPP_BASE;
								sur_pend_d = 1'b0;
								hsur_d     = '0;
								burst_vld  = 1'b1;
								burst      = encode_cp(cp);
							end
						end else if (acc_new < SUR_HI_BASE || acc_new >= SUR_END) begin
							burst_vld = 1'b1;
							burst     = encode_cp(cp);
						end else if (acc_new < SUR_LO_BASE) begin
							sur_pend_d = 1'b1;
							hsur_d     = acc_new[9:0];
						end else begin
							fail_now = 1'b1; fail_kind = ERR_SURROGATE;
						end
					end
				end
				PH_CONT: begin
					if (!(b inside {[8'h80:8'hBF]})) begin
						fail_now = 1'b1; fail_kind = ERR_UTF8;
					end else begin
						cont_left_d = e_cont_left - 2'd1;
						if (cont_left_d == 2'd0) phase_d = PH_NORMAL;
						burst_vld = 1'b1;
					end
				end
				default: burst_vld = 1'b0;
			endcase
		end

		if (fail_now || close_ok) begin
			phase_d = PH_DONE; hex_count_d = '0; hex_accum_d = '0;
			sur_pend_d = 1'b0; hsur_d = '0;      cont_left_d = '0;
			burst_vld  = 1'b1;
			burst      = '0;
			burst.status     = fail_now ? ST_FAIL : ST_OK;
			burst.error_kind = fail_kind;
		end
	end

endmodule

// File: rtl/jsu_queue.sv
// Burst queue between the decoder and the result serializer.
module jsu_queue import jsu_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   wr,
	input  burst_t wr_data,
	input  logic   rd,
	output burst_t rd_data,
	output logic   full,
	output logic   empty
);

	burst_t              mem_q [QDEPTH];
	logic [QPTR_W-1:0]   wr_ptr_q, rd_ptr_q;
	logic [QCNT_W-1:0]   count_q;

	assign full    = (count_q == QCNT_W'(QDEPTH));
	assign empty   = (count_q == '0);
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr) mem_q[wr_ptr_q] <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (rd) rd_ptr_q <= rd_ptr_q + 1'b1;
			case ({wr, rd})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// File: rtl/jsu_back.sv
// Back end: hands out the results of each burst one transaction at a time.
module jsu_back import jsu_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  burst_t  q_head,
	input  logic    q_empty,
	output logic    q_rd,
	output result_t result,
	output logic    empty,
	input  logic    pop
);

	burst_t     cur_q;
	logic [1:0] idx_q;
	logic       cur_vld_q;
	logic       is_last;
	logic       advance;

	assign is_last = (idx_q == cur_q.last_idx);
	// load the next burst when nothing is held or the held one just finished
	assign advance = !cur_vld_q || (pop && is_last);
	assign q_rd    = advance && !q_empty;
	assign empty   = !cur_vld_q;

	always_comb begin
		result.out_byte   = cur_q.bytes[idx_q];
		result.byte_valid = (cur_q.status == ST_RUN);
		result.status     = cur_q.status;
		result.error_kind = cur_q.error_kind;
		result.last       = is_last;
	end

	always_ff @(posedge clk) begin
		if (q_rd) cur_q <= q_head;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_vld_q <= 1'b0;
			idx_q     <= '0;
		end else if (advance) begin
			cur_vld_q <= !q_empty;
			idx_q     <= '0;
		end else if (pop) begin
			idx_q <= idx_q + 2'd1;
		end
	end

endmodule

// File: rtl/json_string_unescape_to_utf8_unit.sv
// Path: the first result of an item passes through the burst queue and then the output
// register before it shows on the result ports.
// Throughput: one input byte per cycle while the burst queue is not full; results leave at one
// per cycle while pop is high, and a 4-burst queue absorbs a \u escape that yields four bytes.
// full follows only the burst queue fill; empty follows only the output register.
// Reset (arst_n low): decoder back to the normal byte phase, queue and output emptied.
module json_string_unescape_to_utf8_unit import jsu_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	output logic     full,
	input  in_item_t item,
	output logic     empty,
	input  logic     pop,
	output result_t  result
);

	burst_t f_burst, q_head;
	logic   f_vld, take, q_wr, q_rd, q_full, q_empty;

	assign full = q_full;
	assign take = push && !q_full;
	assign q_wr = take && f_vld;

	jsu_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.item      (item),
		.take      (take),
		.burst     (f_burst),
		.burst_vld (f_vld)
	);

	jsu_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (q_wr),
		.wr_data (f_burst),
		.rd      (q_rd),
		.rd_data (q_head),
		.full    (q_full),
		.empty   (q_empty)
	);

	jsu_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_head  (q_head),
		.q_empty (q_empty),
		.q_rd    (q_rd),
		.result  (result),
		.empty   (empty),
		.pop     (pop)
	);

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_wr |-> !q_full)
		else $error("burst queue written while full");

	a_close_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && result.status != ST_RUN) |-> (result.last && !result.byte_valid))
		else $error("closing result not alone in its burst");

	a_refill: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && !empty && result.last && !q_empty) |=> !empty)
		else $error("output dropped a waiting burst");

	a_mid_burst: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && !empty && !result.last) |=> (!empty && result.status == ST_RUN))
		else $error("burst cut short");

endmodule

// File: dv/unescape_checker.sv
// Watches both queue ports of the string unescape unit, predicts its output and compares.
`timescale 1ns / 1ps

module unescape_checker import jsu_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	input  logic     full,
	input  in_item_t item,
	input  logic     empty,
	input  logic     pop,
	input  result_t  result,
	output int       mismatches,
	output int       pending
);

	localparam logic [7:0] CH_QUOTE  = "\"";
	localparam logic [7:0] CH_BSLASH = "\\";
	localparam logic [7:0] CH_SLASH  = "/";
	localparam logic [7:0] CH_B      = "b";
	localparam logic [7:0] CH_F      = "f";
	localparam logic [7:0] CH_N      = "n";
	localparam logic [7:0] CH_R      = "r";
	localparam logic [7:0] CH_T      = "t";
	localparam logic [7:0] CH_U      = "u";

	localparam logic [7:0] CODE_BS  = 8'h08;
	localparam logic [7:0] CODE_FF  = 8'h0C;
	localparam logic [7:0] CODE_LF  = 8'h0A;
	localparam logic [7:0] CODE_CR  = 8'h0D;
	localparam logic [7:0] CODE_TAB = 8'h09;

	localparam int PRINT_CAP = 50;

	// decoder state as seen by the prediction
	phase_t      dec_phase = PH_NORMAL;
	logic [1:0]  hex_taken = '0;
	logic [15:0] hex_acc = '0;
	logic        high_waiting = 1'b0;
	logic [9:0]  high_bits = '0;
	logic [1:0]  cont_left = '0;

	result_t expected_bytes[$];
	result_t item_results[$];
	int      result_no = 0;
	int      mismatch_cnt = 0;
	int      pending_cnt = 0;

	assign mismatches = mismatch_cnt;
	assign pending    = pending_cnt;

	task automatic clear_decoder();
		dec_phase = PH_NORMAL;
		hex_taken = '0;
		hex_acc = '0;
		high_waiting = 1'b0;
		high_bits = '0;
		cont_left = '0;
	endtask

	task automatic give_byte(input logic [7:0] b);
		result_t r;
		r = '0;
		r.out_byte = b;
		r.byte_valid = 1'b1;
		r.status = ST_RUN;
		r.error_kind = ERR_NONE;
		item_results = {item_results, r};
	endtask

	task automatic close_string(input status_t st, input err_t ek);
		result_t r;
		clear_decoder();
		dec_phase = PH_DONE;
		r = '0;
		r.status = st;
		r.error_kind = ek;
		item_results = {item_results, r};
	endtask

	task automatic give_code_point(input logic [20:0] cp);
		if (cp < 21'h80) begin
			give_byte({1'b0, cp[6:0]});
		end else if (cp < 21'h800) begin
			give_byte({3'b110, cp[10:6]});
			give_byte({2'b10, cp[5:0]});
		end else if (cp < 21'h10000) begin
			give_byte({4'b1110, cp[15:12]});
			give_byte({2'b10, cp[11:6]});
			give_byte({2'b10, cp[5:0]});
		end else begin
			give_byte({5'b11110, cp[20:18]});
			give_byte({2'b10, cp[17:12]});
			give_byte({2'b10, cp[11:6]});
			give_byte({2'b10, cp[5:0]});
		end
	endtask

	// bit 4 set when the byte is a hex digit
	function automatic logic [4:0] hex_digit(input logic [7:0] b);
		if (b >= "0" && b <= "9") return {1'b1, 4'(b - "0")};
		if (b >= "a" && b <= "f") return {1'b1, 4'(b - "a" + 10)};
		if (b >= "A" && b <= "F") return {1'b1, 4'(b - "A" + 10)};
		return '0;
	endfunction

	task automatic end_of_hex(input logic [15:0] v16);
		logic [20:0] cp;
		dec_phase = PH_NORMAL;
		hex_taken = '0;
		hex_acc = '0;
		if (high_waiting) begin
			if (v16 >= SUR_END || v16 < SUR_LO_BASE) begin
				close_string(ST_FAIL, ERR_SURROGATE);
			end else begin
				cp = {1'b0, high_bits, v16[9:0]} + SUPP_BASE;
				high_waiting = 1'b0;
				high_bits = '0;
				give_code_point(cp);
			end
		end else if (v16 < SUR_HI_BASE || v16 >= SUR_END) begin
			give_code_point({5'b0, v16});
		end else if (v16 < SUR_LO_BASE) begin
			// hold the high half until its partner arrives
			high_waiting = 1'b1;
			high_bits = v16[9:0];
		end else begin
			close_string(ST_FAIL, ERR_SURROGATE);
		end
	endtask

	task automatic decode_byte(input logic [7:0] b);
		logic [4:0] d;
		case (dec_phase)
			PH_NORMAL: begin
				if (high_waiting && b != CH_BSLASH) begin
					close_string(ST_FAIL, ERR_SURROGATE);
				end else if (b == CH_QUOTE) begin
					close_string(ST_OK, ERR_NONE);
				end else if (b == CH_BSLASH) begin
					dec_phase = PH_ESCAPE;
				end else if (b >= 8'h80 && b < 8'hC0) begin
					close_string(ST_FAIL, ERR_UTF8);
				end else begin
					if (b >= 8'hC0) begin
						cont_left = (b >= 8'hF0) ? 2'd3 : (b >= 8'hE0) ? 2'd2 : 2'd1;
						dec_phase = PH_CONT;
					end
					give_byte(b);
				end
			end
			PH_ESCAPE: begin
				if (high_waiting && b != CH_U) begin
					close_string(ST_FAIL, ERR_SURROGATE);
				end else begin
					dec_phase = PH_NORMAL;
					case (b)
						CH_QUOTE, CH_BSLASH, CH_SLASH: give_byte(b);
						CH_B: give_byte(CODE_BS);
						CH_F: give_byte(CODE_FF);
						CH_N: give_byte(CODE_LF);
						CH_R: give_byte(CODE_CR);
						CH_T: give_byte(CODE_TAB);
						CH_U: begin
							dec_phase = PH_HEX;
							hex_taken = '0;
							hex_acc = '0;
						end
						default: close_string(ST_FAIL, ERR_ESCAPE);
					endcase
				end
			end
			PH_HEX: begin
				d = hex_digit(b);
				if (!d[4]) begin
					close_string(ST_FAIL, ERR_HEX);
				end else begin
					hex_acc = {hex_acc[11:0], d[3:0]};
					if (hex_taken == 2'd3) end_of_hex(hex_acc);
					else hex_taken = hex_taken + 2'd1;
				end
			end
			PH_CONT: begin
				if (b < 8'h80 || b >= 8'hC0) begin
					close_string(ST_FAIL, ERR_UTF8);
				end else begin
					cont_left = cont_left - 2'd1;
					if (cont_left == 2'd0) dec_phase = PH_NORMAL;
					give_byte(b);
				end
			end
			default: ;
		endcase
	endtask

	task automatic predict_item(input in_item_t it);
		item_results.delete();
		if (it.start_req) clear_decoder();
		if (dec_phase != PH_DONE) begin
			if (it.at_end) close_string(ST_FAIL, ERR_EARLY_END);
			else decode_byte(it.in_byte);
		end
		if (item_results.size() > 0) item_results[item_results.size() - 1].last = 1'b1;
		expected_bytes = {expected_bytes, item_results};
	endtask

	task automatic report(input string what, input int got, input int want);
		mismatch_cnt++;
		if (mismatch_cnt <= PRINT_CAP)
			$display("%0t ns: result %0d: %s is %0h, expected %0h", $time, result_no, what,
				got, want);
	endtask

	always @(posedge clk) begin
		result_t want;
		if (arst_n) begin
			if (pop && !empty) begin
				if (expected_bytes.size() == 0) begin
					report("unexpected transaction, byte", int'(result.out_byte), 0);
				end else begin
					want = expected_bytes.pop_front();
					if (result.out_byte !== want.out_byte)
						report("out_byte", int'(result.out_byte), int'(want.out_byte));
					if (result.byte_valid !== want.byte_valid)
						report("byte_valid", int'(result.byte_valid),
							int'(want.byte_valid));
					if (result.status !== want.status)
						report("status", int'(result.status), int'(want.status));
					if (result.error_kind !== want.error_kind)
						report("error_kind", int'(result.error_kind),
							int'(want.error_kind));
					if (result.last !== want.last)
						report("last", int'(result.last), int'(want.last));
				end
				result_no++;
			end
			if (push && !full) predict_item(item);
			pending_cnt <= expected_bytes.size();
		end
	end

endmodule

// File: dv/testbench.sv
// Top of the string unescape testbench: clock, reset, stimulus, flow control and verdict.
`timescale 1ns / 1ps

module testbench import jsu_pkg::*;;

	localparam int RANDOM_ITEMS   = 200;
	localparam int MAX_GAP        = 18;
	localparam int DRAIN_CYCLES   = 20;
	localparam int WATCHDOG_LIMIT = 2000;

	logic     clk = 1'b0;
	logic     arst_n;
	logic     push;
	logic     full;
	in_item_t item;
	logic     empty;
	logic     pop;
	result_t  result;
	int       mismatches;
	int       pending;

	in_item_t   stim_q[$];
	logic       open_start;
	logic       no_gaps = 1'b0;
	logic [7:0] stretch_cnt = '0;
	int         idle_cycles = 0;
	logic [7:0] esc_letter [8] = '{"\"", "\\", "/", "b", "f", "n", "r", "t"};

	json_string_unescape_to_utf8_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (full),
		.item   (item),
		.empty  (empty),
		.pop    (pop),
		.result (result)
	);

	unescape_checker checker_i (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.item       (item),
		.empty      (empty),
		.pop        (pop),
		.result     (result),
		.mismatches (mismatches),
		.pending    (pending)
	);

	always #5 clk = ~clk;

	// alternate stretches with random gaps and stretches running flat out
	always @(posedge clk) begin
		stretch_cnt <= stretch_cnt + 8'd1;
		if (stretch_cnt == 8'd0) no_gaps <= ($urandom_range(0, 2) == 0);
	end

	always @(posedge clk) begin
		if (!arst_n || (push && !full) || (pop && !empty)) begin
			idle_cycles <= 0;
		end else if (idle_cycles == WATCHDOG_LIMIT) begin
			$display("testbench NOT OK");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	function automatic int draw_gap();
		return no_gaps ? 0 : int'($urandom_range(0, MAX_GAP));
	endfunction

	function automatic logic [7:0] hex_char(input logic [3:0] nib);
		if (nib < 10) return "0" + nib;
		if ($urandom_range(0, 1)) return "a" + (nib - 4'd10);
		return "A" + (nib - 4'd10);
	endfunction

	task automatic put_byte(input logic [7:0] b);
		in_item_t it;
		it.in_byte = b;
		it.at_end = 1'b0;
		it.start_req = open_start;
		open_start = 1'b0;
		stim_q = {stim_q, it};
	endtask

	task automatic put_end();
		in_item_t it;
		it.in_byte = 8'($urandom_range(0, 255));
		it.at_end = 1'b1;
		it.start_req = open_start;
		open_start = 1'b0;
		stim_q = {stim_q, it};
	endtask

	task automatic put_hex(input logic [15:0] v);
		put_byte("\\");
		put_byte("u");
		put_byte(hex_char(v[15:12]));
		put_byte(hex_char(v[11:8]));
		put_byte(hex_char(v[7:4]));
		put_byte(hex_char(v[3:0]));
	endtask

	task automatic put_plain_char();
		logic [7:0] b;
		b = 8'($urandom_range(0, 127));
		while (b == "\"" || b == "\\") b = 8'($urandom_range(0, 127));
		put_byte(b);
	endtask

	task automatic put_multibyte();
		logic [7:0] lead;
		int         n;
		lead = 8'($urandom_range(8'hC0, 8'hFF));
		n = (lead >= 8'hF0) ? 3 : (lead >= 8'hE0) ? 2 : 1;
		put_byte(lead);
		repeat (n) put_byte(8'($urandom_range(8'h80, 8'hBF)));
	endtask

	// a piece, usually malformed, that can stop the string in one way or another
	task automatic put_broken();
		case ($urandom_range(0, 6))
			0: put_byte(8'($urandom_range(0, 255)));
			1: begin
				put_byte("\\");
				put_byte(8'($urandom_range(0, 255)));
			end
			2: begin
				put_byte("\\");
				put_byte("u");
				repeat ($urandom_range(0, 3)) put_byte(hex_char(4'($urandom_range(0, 15))));
				put_byte(8'($urandom_range(0, 255)));
			end
			3: begin
				put_byte(8'($urandom_range(8'hC0, 8'hFF)));
				put_byte(8'($urandom_range(0, 255)));
			end
			4: begin
				put_hex(SUR_HI_BASE | 16'($urandom_range(0, 1023)));
				if ($urandom_range(0, 1)) put_byte("\\");
				put_byte(8'($urandom_range(0, 255)));
			end
			5: begin
				put_byte("\\");
				if ($urandom_range(0, 1)) put_byte("u");
				put_end();
			end
			default: put_hex(SUR_LO_BASE | 16'($urandom_range(0, 1023)));
		endcase
	endtask

	task automatic gen_string();
		int          n;
		int          kind;
		logic [15:0] v;
		logic        broken;
		broken = 1'b0;
		open_start = 1'b1;
		n = $urandom_range(0, 8);
		for (int k = 0; k < n && !broken; k++) begin
			kind = $urandom_range(0, 99);
			if (kind < 30) begin
				put_plain_char();
			end else if (kind < 45) begin
				put_multibyte();
			end else if (kind < 60) begin
				put_byte("\\");
				put_byte(esc_letter[$urandom_range(0, 7)]);
			end else if (kind < 75) begin
				v = 16'($urandom_range(0, 16'hFFFF));
				put_hex(v);
				if (v >= SUR_HI_BASE && v < SUR_LO_BASE)
					put_hex(SUR_LO_BASE | 16'($urandom_range(0, 1023)));
			end else if (kind < 92) begin
				put_hex(SUR_HI_BASE | 16'($urandom_range(0, 1023)));
				put_hex(SUR_LO_BASE | 16'($urandom_range(0, 1023)));
			end else begin
				put_broken();
				broken = 1'b1;
			end
		end
		kind = $urandom_range(0, 19);
		if (kind < 16) put_byte("\"");
		else if (kind < 18) put_end();
		// bytes after the string has stopped must be swallowed
		if ($urandom_range(0, 4) == 0) begin
			repeat ($urandom_range(1, 3)) begin
				if ($urandom_range(0, 4) == 0) put_end();
				else put_byte(8'($urandom_range(0, 255)));
			end
		end
	endtask

	task automatic build_stimulus();
		int directed;
		open_start = 1'b1;
		put_byte(8'h00);
		put_byte(8'h1F);
		put_byte(8'hF8);
		put_byte(8'h80);
		put_byte(8'hBF);
		put_byte(8'hBF);
		put_hex(16'hFFFF);
		put_hex(16'hDBFF);
		put_hex(16'hDFFF);
		put_byte("\"");
		put_byte("x");
		open_start = 1'b1;
		put_end();
		open_start = 1'b1;
		put_byte(8'h80);
		open_start = 1'b1;
		put_byte("\\");
		put_byte("q");
		directed = stim_q.size();
		while (stim_q.size() < directed + RANDOM_ITEMS) gen_string();
	endtask

	// result side: random stalls before each transaction
	initial begin
		int gap;
		pop = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			gap = draw_gap();
			if (gap > 0) begin
				pop <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			pop <= 1'b1;
			@(posedge clk);
			while (empty) @(posedge clk);
		end
	end

	initial begin
		int gap;
		arst_n = 1'b0;
		push = 1'b0;
		item = '0;
		build_stimulus();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (stim_q[i]) begin
			gap = draw_gap();
			if (gap > 0) begin
				push <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			push <= 1'b1;
			item <= stim_q[i];
			@(posedge clk);
			while (full) @(posedge clk);
		end
		push <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("testbench OK");
		else
			$display("testbench NOT OK");
		$finish;
	end

endmodule
